// File: sv/whq_pkg.sv
// ----------------------------------------------------------------------------
// whq_pkg
// shared types and constants of the weighted histogram with mode query
// ----------------------------------------------------------------------------
`default_nettype none

package whq_pkg;

    // default bin count and reset value of the bins-in-use register
    localparam int          NUM_BINS_DEF = 128;
    localparam logic [7:0]  BINS_RESET   = 8'd128;

    // field widths
    localparam int COUNT_W = 32;   // bin count, Q24.8
    localparam int TOTAL_W = 40;   // total weight, Q32.8
    localparam int SUM_W   = 48;   // weighted sum, Q40.8
    localparam int PROD_W  = 24;   // bin times weight, Q16.8

    // item opcodes
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    // control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// File: sv/weighted_histogram_with_mode_query.sv
// ----------------------------------------------------------------------------
// weighted_histogram_with_mode_query
// weighted histogram in a synchronous memory with clear and mode query
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one item: tuser = opcode, tdata = sample, weight and
//   query range. m_axis returns exactly one result item per input item.
//   cfg_wr_en / cfg_wr_data write the bins-in-use register while idle.
// operation (one item at a time)
//   add:    bin read issued at accept, then read-modify-write of the bin
//           and both totals, then the output
//   clear:  all bins drop at once through per-bin valid flags
//   query:  one memory read per bin in range, through the single read
//           port of the bin memory
//   a new item is taken the cycle after the previous result is handed over
// reset
//   all bins read as zero, totals zero, bins in use = 128, no clearing pass
// stall
//   a result waits in the output register; the next item is still accepted
//   and processed, and its result waits until the output register frees up
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_histogram_with_mode_query #(
    parameter int NUM_BINS = whq_pkg::NUM_BINS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration: bins in use
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data,
    // input items
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // sample_value[7:0], weight[23:8], range_start[31:24], range_end[39:32]
    input  wire logic [39:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    // result items
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // best_bin[7:0], best_count[39:8], total_weight[79:40], weighted_sum[127:80]
    output      logic [127:0] m_axis_tdata,
    // range_empty[0]
    output      logic [0:0]   m_axis_tuser
);

    localparam int         ADDR_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [7:0] NUM_BINS_B = 8'(NUM_BINS);
    localparam int         COUNT_W    = whq_pkg::COUNT_W;
    localparam int         TOTAL_W    = whq_pkg::TOTAL_W;
    localparam int         SUM_W      = whq_pkg::SUM_W;
    localparam int         PROD_W     = whq_pkg::PROD_W;

    // input fields
    logic [7:0]  in_value;
    logic [15:0] in_weight;
    logic [7:0]  in_start;
    logic [7:0]  in_end;

    assign in_value  = s_axis_tdata[7:0];
    assign in_weight = s_axis_tdata[23:8];
    assign in_start  = s_axis_tdata[31:24];
    assign in_end    = s_axis_tdata[39:32];

    // control registers
    whq_pkg::state_t      state_reg, state_next;
    logic [7:0]           bins_reg;
    logic [NUM_BINS-1:0]  valid_reg, valid_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 pend_reg, pend_next;
    logic                 found_reg, found_next;
    logic                 m_valid_reg, m_valid_next;

    // payload registers
    logic [ADDR_W-1:0]    bin_reg, bin_next;
    logic [15:0]          weight_reg, weight_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [7:0]           scan_reg, scan_next;
    logic [7:0]           stop_reg, stop_next;
    logic [7:0]           pend_bin_reg, pend_bin_next;
    logic [7:0]           res_bin_reg, res_bin_next;
    logic [COUNT_W-1:0]   res_count_reg, res_count_next;
    logic                 res_empty_reg, res_empty_next;
    logic [127:0]         m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;

    // bin memory
    logic [COUNT_W-1:0]   mem [NUM_BINS];
    logic [COUNT_W-1:0]   rdata_reg;
    logic                 rvalid_reg;
    logic [ADDR_W-1:0]    mem_raddr;
    logic                 mem_we;
    logic [COUNT_W-1:0]   mem_wdata;

    // helper signals
    logic                 accept;
    logic [7:0]           use_eff;
    logic [7:0]           in_bin;
    logic [7:0]           in_stop;
    logic                 scan_issue;
    logic                 out_free;
    logic [COUNT_W-1:0]   cnt_rd;
    logic [COUNT_W:0]     cnt_sum;
    logic [TOTAL_W:0]     total_sum;
    logic [SUM_W:0]       wsum_sum;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    // effective bin count: 0 acts as 1, large values cap at the bin count
    always_comb
    begin
        if (bins_reg == 8'd0)
            use_eff = 8'd1;
        else if (bins_reg > NUM_BINS_B)
            use_eff = NUM_BINS_B;
        else
            use_eff = bins_reg;
    end

    assign in_bin     = (in_value >= use_eff) ? (use_eff - 8'd1) : in_value;
    assign in_stop    = (in_end < use_eff) ? in_end : use_eff;
    assign scan_issue = (scan_reg < stop_reg);

    // a bin never written since the last clear reads as zero
    assign cnt_rd    = rvalid_reg ? rdata_reg : '0;
    assign cnt_sum   = {1'b0, cnt_rd} + {{(COUNT_W - 15){1'b0}}, weight_reg};
    assign total_sum = {1'b0, total_reg} + {{(TOTAL_W - 15){1'b0}}, weight_reg};
    assign wsum_sum  = {1'b0, sum_reg} + {{(SUM_W - PROD_W + 1){1'b0}}, prod_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            whq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (whq_pkg::opcode_t'(s_axis_tuser))
                        whq_pkg::OP_ADD:   state_next = whq_pkg::ST_ADD;
                        whq_pkg::OP_QUERY: state_next = (in_start < in_stop) ?
                                                        whq_pkg::ST_SCAN :
                                                        whq_pkg::ST_FINISH;
                        default:           state_next = whq_pkg::ST_FINISH;
                    endcase
                end
            end
            whq_pkg::ST_ADD:
                state_next = whq_pkg::ST_FINISH;
            whq_pkg::ST_SCAN:
            begin
                if (!scan_issue && !pend_reg)
                    state_next = whq_pkg::ST_FINISH;
            end
            whq_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = whq_pkg::ST_IDLE;
            end
            default:
                state_next = whq_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        s_axis_tready  = (state_reg == whq_pkg::ST_IDLE);
        valid_next     = valid_reg;
        total_next     = total_reg;
        sum_next       = sum_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        bin_next       = bin_reg;
        weight_next    = weight_reg;
        prod_next      = prod_reg;
        scan_next      = scan_reg;
        stop_next      = stop_reg;
        pend_bin_next  = scan_reg;
        res_bin_next   = res_bin_reg;
        res_count_next = res_count_reg;
        res_empty_next = res_empty_reg;
        mem_raddr      = in_bin[ADDR_W-1:0];
        mem_we         = 1'b0;
        mem_wdata      = cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        case (state_reg)
            whq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_bin_next   = 8'd0;
                    res_count_next = '0;
                    res_empty_next = 1'b0;
                    bin_next       = in_bin[ADDR_W-1:0];
                    weight_next    = in_weight;
                    prod_next      = {16'd0, in_bin} * {8'd0, in_weight};
                    case (whq_pkg::opcode_t'(s_axis_tuser))
                        whq_pkg::OP_CLEAR:
                        begin
                            valid_next = '0;
                            total_next = '0;
                            sum_next   = '0;
                        end
                        whq_pkg::OP_QUERY:
                        begin
                            res_empty_next = !(in_start < in_stop);
                            scan_next      = in_start;
                            stop_next      = in_stop;
                            found_next     = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            whq_pkg::ST_ADD:
            begin
                // read-modify-write of the bin, saturating totals
                mem_we              = 1'b1;
                valid_next[bin_reg] = 1'b1;
                total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                sum_next   = wsum_sum[SUM_W] ? '1 : wsum_sum[SUM_W-1:0];
            end
            whq_pkg::ST_SCAN:
            begin
                // one read issued per cycle, compared the cycle after
                mem_raddr = scan_reg[ADDR_W-1:0];
                pend_next = scan_issue;
                if (scan_issue)
                    scan_next = scan_reg + 8'd1;
                if (pend_reg && (!found_reg || cnt_rd >= res_count_reg))
                begin
                    found_next     = 1'b1;
                    res_bin_next   = pend_bin_reg;
                    res_count_next = cnt_rd;
                end
            end
            whq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {sum_reg, total_reg, res_count_reg, res_bin_reg};
                    m_user_next  = res_empty_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // bin memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[bin_reg] <= mem_wdata;
        rdata_reg  <= mem[mem_raddr];
        rvalid_reg <= valid_next[mem_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= whq_pkg::ST_IDLE;
            bins_reg    <= whq_pkg::BINS_RESET;
            valid_reg   <= '0;
            total_reg   <= '0;
            sum_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_wr_en)
                bins_reg <= cfg_wr_data;
            valid_reg   <= valid_next;
            total_reg   <= total_next;
            sum_reg     <= sum_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        weight_reg    <= weight_next;
        prod_reg      <= prod_next;
        scan_reg      <= scan_next;
        stop_reg      <= stop_next;
        pend_bin_reg  <= pend_bin_next;
        res_bin_reg   <= res_bin_next;
        res_count_reg <= res_count_next;
        res_empty_reg <= res_empty_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

endmodule

`default_nettype wire

// File: dv/weighted_histogram_with_mode_query_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_histogram_with_mode_query_tb
// self-checking bench for the weighted histogram with mode query
// ----------------------------------------------------------------------------
// a short table of directed items (reset state, field extremes, clamping,
// empty ranges, ties, clear, unused opcode) is followed by random phases,
// each under its own bins-in-use setting. every accepted item runs through a
// local copy of the histogram; each result item is compared field by field
// against the oldest prediction. both stream sides idle at random, and the
// result side holds off for long stretches so the block backs up its input.
// ----------------------------------------------------------------------------

module weighted_histogram_with_mode_query_tb;

    localparam int          NUM_BINS    = whq_pkg::NUM_BINS_DEF;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;    // opcode with no effect
    localparam int          PHASE_ITEMS = 60;      // random items per setting
    localparam int          HOLD_CYCLES = 300;     // long result-side hold off
    localparam int          MAX_REPORTS = 10;

    // one input item, fields in the order of the stream packing
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  sample;
        logic [15:0] weight;
        logic [7:0]  range_start;
        logic [7:0]  range_end;
    } hist_item_t;

    // one result item
    typedef struct packed {
        logic [7:0]  best_bin;
        logic [31:0] best_count;
        logic        empty;
        logic [39:0] total_weight;
        logic [47:0] weighted_sum;
    } hist_result_t;

    // directed row: item, and a typed-in result where it is obvious
    typedef struct packed {
        hist_item_t   item;
        logic         fixed;
        hist_result_t result;
    } directed_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_wr_en;
    logic [7:0]   cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    // local histogram state, updated on every accepted item
    logic [31:0]  model_bins [NUM_BINS];
    logic [39:0]  model_total;
    logic [47:0]  model_sum;
    logic [7:0]   model_bins_reg;

    hist_result_t predicted_results [$];
    int           mismatches = 0;
    bit           no_idle = 1'b0;        // stretch with no gaps on either side
    bit           hold_request = 1'b0;   // asks the result side for a long hold

    logic [7:0]   phase_bins [9] = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd129,
                                     8'd64, 8'd127, 8'd128, 8'd0};

    // directed table
    // fixed rows: reset state, empty range, unused opcode, first add, clear, query after clear
    directed_row_t directed_rows [22] = '{
        // query over everything after reset: all zero, the later bin wins
        '{'{whq_pkg::OP_QUERY, 8'd0, 16'h0000, 8'd0, 8'd255}, 1'b1,
          '{8'd127, 32'd0, 1'b0, 40'd0, 48'd0}},
        // start above end: empty range
        '{'{whq_pkg::OP_QUERY, 8'd0, 16'h0000, 8'd255, 8'd0}, 1'b1,
          '{8'd0, 32'd0, 1'b1, 40'd0, 48'd0}},
        // unused opcode with all ones, nothing changes
        '{'{OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1,
          '{8'd0, 32'd0, 1'b0, 40'd0, 48'd0}},
        // largest weight into bin 0: weighted sum stays zero
        '{'{whq_pkg::OP_ADD, 8'd0, 16'hFFFF, 8'd0, 8'd0}, 1'b1,
          '{8'd0, 32'd0, 1'b0, 40'h00_0000_FFFF, 48'd0}},
        // largest value clamps to the last bin
        '{'{whq_pkg::OP_ADD, 8'd255, 16'hFFFF, 8'd0, 8'd0}, 1'b0, '0},
        '{'{whq_pkg::OP_ADD, 8'd127, 16'h0001, 8'd0, 8'd0}, 1'b0, '0},
        '{'{whq_pkg::OP_ADD, 8'd128, 16'h0100, 8'd0, 8'd0}, 1'b0, '0},
        // zero weight
        '{'{whq_pkg::OP_ADD, 8'd5, 16'h0000, 8'd0, 8'd0}, 1'b0, '0},
        '{'{whq_pkg::OP_ADD, 8'hAA, 16'h5555, 8'h55, 8'hAA}, 1'b0, '0},
        '{'{whq_pkg::OP_ADD, 8'h55, 16'hAAAA, 8'hAA, 8'h55}, 1'b0, '0},
        '{'{whq_pkg::OP_QUERY, 8'd0, 16'h0000, 8'd0, 8'd255}, 1'b0, '0},
        '{'{whq_pkg::OP_QUERY, 8'd0, 16'h0000, 8'd5, 8'd6}, 1'b0, '0},
        '{'{whq_pkg::OP_QUERY, 8'd0, 16'h0000, 8'd127, 8'd255}, 1'b0, '0},
        '{'{whq_pkg::OP_QUERY, 8'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '0},
        // start beyond the bins in use
        '{'{whq_pkg::OP_QUERY, 8'd0, 16'h0000, 8'd200, 8'd255}, 1'b0, '0},
        '{'{whq_pkg::OP_QUERY, 8'd0, 16'h0000, 8'd0, 8'd1}, 1'b0, '0},
        '{'{whq_pkg::OP_CLEAR, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1,
          '{8'd0, 32'd0, 1'b0, 40'd0, 48'd0}},
        '{'{whq_pkg::OP_QUERY, 8'd0, 16'h0000, 8'd0, 8'd128}, 1'b1,
          '{8'd127, 32'd0, 1'b0, 40'd0, 48'd0}},
        // equal counts in two bins: the later one wins
        '{'{whq_pkg::OP_ADD, 8'd3, 16'h0100, 8'd0, 8'd0}, 1'b0, '0},
        '{'{whq_pkg::OP_ADD, 8'd9, 16'h0100, 8'd0, 8'd0}, 1'b0, '0},
        '{'{whq_pkg::OP_QUERY, 8'd0, 16'h0000, 8'd0, 8'd255}, 1'b0, '0},
        '{'{OP_UNUSED, 8'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '0}
    };

    weighted_histogram_with_mode_query #(
        .NUM_BINS      (NUM_BINS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // register value 0 means one bin, anything above the bin count means all
    function automatic int effective_bins();
        if (model_bins_reg == 8'd0)
        begin
            return 1;
        end
        if (model_bins_reg > NUM_BINS)
        begin
            return NUM_BINS;
        end
        return int'(model_bins_reg);
    endfunction

    function automatic void clear_histogram();
        for (int i = 0; i < NUM_BINS; i++)
        begin
            model_bins[i] = '0;
        end
        model_total = '0;
        model_sum   = '0;
    endfunction

    // applies one item to the local histogram and returns its result
    function automatic hist_result_t apply_histogram_item(hist_item_t it);
        hist_result_t res;
        int           use_bins;
        int           bin;
        int           stop;
        logic [32:0]  bin_next;
        logic [40:0]  total_next;
        logic [48:0]  sum_next;
        logic [23:0]  product;

        res      = '0;
        use_bins = effective_bins();
        case (it.op)
            whq_pkg::OP_ADD:
            begin
                // clamp the value to the last bin in use
                bin = (int'(it.sample) >= use_bins) ? use_bins - 1 : int'(it.sample);
                bin_next = {1'b0, model_bins[bin]} + {17'd0, it.weight};
                model_bins[bin] = bin_next[32] ? '1 : bin_next[31:0];
                total_next = {1'b0, model_total} + {25'd0, it.weight};
                model_total = total_next[40] ? '1 : total_next[39:0];
                product  = 24'(bin) * {8'd0, it.weight};
                sum_next = {1'b0, model_sum} + {25'd0, product};
                model_sum = sum_next[48] ? '1 : sum_next[47:0];
            end
            whq_pkg::OP_CLEAR:
            begin
                clear_histogram();
            end
            whq_pkg::OP_QUERY:
            begin
                stop = (int'(it.range_end) < use_bins) ? int'(it.range_end) : use_bins;
                if (int'(it.range_start) >= stop)
                begin
                    res.empty = 1'b1;
                end
                else
                begin
                    // >= lets the later bin take a tie
                    for (int i = int'(it.range_start); i < stop; i++)
                    begin
                        if (i == int'(it.range_start) || model_bins[i] >= res.best_count)
                        begin
                            res.best_bin   = 8'(i);
                            res.best_count = model_bins[i];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.total_weight = model_total;
        res.weighted_sum = model_sum;
        return res;
    endfunction

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;

        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // mostly adds, values mostly inside the bins in use, ranges mostly useful
    function automatic hist_item_t random_histogram_item();
        hist_item_t it;
        int         use_bins;
        int         r;
        int         w;

        use_bins       = effective_bins();
        it.sample      = 8'($urandom_range(255));
        it.weight      = 16'($urandom_range(65535));
        it.range_start = 8'($urandom_range(255));
        it.range_end   = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 72)
        begin
            it.op = whq_pkg::OP_ADD;
            if ($urandom_range(9) < 7)
            begin
                it.sample = 8'($urandom_range(use_bins - 1));
            end
            w = $urandom_range(9);
            if (w < 3)
            begin
                it.weight = 16'($urandom_range(1023));
            end
            else if (w < 5)
            begin
                // a few fixed weights make equal counts, hence ties
                it.weight = 16'($urandom_range(1, 2) << 8);
            end
        end
        else if (r < 94)
        begin
            it.op = whq_pkg::OP_QUERY;
            if ($urandom_range(9) < 7)
            begin
                it.range_start = 8'($urandom_range(use_bins - 1));
                it.range_end   = 8'($urandom_range(int'(it.range_start), use_bins));
            end
        end
        else if (r < 97)
        begin
            it.op = whq_pkg::OP_CLEAR;
        end
        else
        begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    // offers one item from a falling edge until it is taken, then predicts it
    task automatic send_item(hist_item_t it, logic fixed, hist_result_t fixed_res);
        int           gap;
        hist_result_t pred;

        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.op;
        s_axis_tdata  = {it.range_end, it.range_start, it.weight, it.sample};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = apply_histogram_item(it);
        predicted_results.push_back(fixed ? fixed_res : pred);
        @(negedge clk);
    endtask

    // register write once every result has come back and the block is idle
    task automatic write_bins_in_use(logic [7:0] value);
        s_axis_tvalid = 1'b0;
        while (predicted_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en      = 1'b0;
        model_bins_reg = value;
    endtask

    task automatic check_result(hist_result_t got);
        hist_result_t exp;

        if (predicted_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%0t: result item with nothing expected: bin %0d count %h",
                         $realtime, got.best_bin, got.best_count);
            end
        end
        else
        begin
            exp = predicted_results.pop_front();
            if (got.best_bin !== exp.best_bin || got.best_count !== exp.best_count ||
                got.empty !== exp.empty || got.total_weight !== exp.total_weight ||
                got.weighted_sum !== exp.weighted_sum)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected bin %0d count %h empty %b total %h sum %h",
                             exp.best_bin, exp.best_count, exp.empty,
                             exp.total_weight, exp.weighted_sum);
                    $display("  actual   bin %0d count %h empty %b total %h sum %h",
                             got.best_bin, got.best_count, got.empty,
                             got.total_weight, got.weighted_sum);
                end
            end
        end
    endtask

    // result side: sampled at the rising edge
    initial
    begin
        hist_result_t got;

        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.best_bin     = m_axis_tdata[7:0];
                got.best_count   = m_axis_tdata[39:8];
                got.total_weight = m_axis_tdata[79:40];
                got.weighted_sum = m_axis_tdata[127:80];
                got.empty        = m_axis_tuser[0];
                check_result(got);
            end
        end
    end

    // result side ready: random bursts and stalls, plus long holds on request
    initial
    begin
        int stall_left;
        int burst_left;

        stall_left    = 0;
        burst_left    = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    stall_left = pick_gap();
                end
            end
        end
    end

    // stimulus
    initial
    begin
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        clear_histogram();
        model_bins_reg = whq_pkg::BINS_RESET;
        phase_bins[8]  = 8'($urandom_range(3, 126));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
        begin
            send_item(directed_rows[k].item, directed_rows[k].fixed, directed_rows[k].result);
        end

        // random phases, one bins-in-use setting each
        foreach (phase_bins[p])
        begin
            write_bins_in_use(phase_bins[p]);
            no_idle = (p == 2 || p == 5);
            if (p == 1 || p == 6)
            begin
                hold_request = 1'b1;
            end
            repeat (PHASE_ITEMS)
            begin
                send_item(random_histogram_item(), 1'b0, '0);
            end
        end
        s_axis_tvalid = 1'b0;

        while (predicted_results.size() != 0)
        begin
            @(negedge clk);
        end
        // longest query walks every bin, leave room for a stray result
        repeat (NUM_BINS + 20) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("weighted_histogram_with_mode_query_tb passed");
        end
        else
        begin
            $display("weighted_histogram_with_mode_query_tb failed");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("weighted_histogram_with_mode_query_tb failed");
        $finish;
    end

endmodule
